### rtl/lpg_pkg.sv
// Package for the lexicographic permutation generator.
// Item kinds, register indexes, control/status structs and the request limit table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpg_pkg;

  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_RESTART = 2'd1;
  localparam logic [1:0] KIND_REQUEST = 2'd2;

  localparam logic       REG_ELEMENT_COUNT = 1'b0;
  localparam logic [3:0] COUNT_RESET       = 4'd8;

  typedef struct packed {
    logic load;
    logic restart;
    logic start_req;
    logic set_first;
    logic scan;
    logic srch;
    logic swap;
    logic rev_a;
    logic rev_b;
    logic emit;
    logic mark;
  } lpg_cmd_t;

  typedef struct packed {
    logic first;
    logic more;
    logic lim_zero;
    logic found;
    logic rev_go;
    logic j_last;
    logic rem_one;
    logic out_free;
  } lpg_sts_t;

  // most whole permutations of n elements that fit in 64 results
  function automatic logic [6:0] max_perms(input logic [4:0] n);
    logic [6:0] r;
    case (n)
      5'd1:    r = 7'd64;
      5'd2:    r = 7'd32;
      5'd3:    r = 7'd21;
      5'd4:    r = 7'd16;
      5'd5:    r = 7'd12;
      5'd6:    r = 7'd10;
      5'd7:    r = 7'd9;
      5'd8:    r = 7'd8;
      5'd9:    r = 7'd7;
      5'd10:   r = 7'd6;
      5'd11:   r = 7'd5;
      5'd12:   r = 7'd5;
      5'd13:   r = 7'd4;
      5'd14:   r = 7'd4;
      5'd15:   r = 7'd4;
      5'd16:   r = 7'd4;
      default: r = 7'd64;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/lpg_if.sv
// Request and result channel interfaces for the permutation generator.
// Valid/ready handshake with the item payload; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface lpg_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  position;
  logic [31:0] element_value;
  logic [3:0]  perm_count;

  modport source (output valid, kind, position, element_value, perm_count, input ready);
  modport sink   (input valid, kind, position, element_value, perm_count, output ready);
endinterface

interface lpg_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_value;
  logic [2:0]  out_index;
  logic        perm_end;
  logic        exhausted;
  logic        more_available;
  logic        last;

  modport source (output valid, out_value, out_index, perm_end, exhausted, more_available,
                  last, input ready);
  modport sink   (input valid, out_value, out_index, perm_end, exhausted, more_available,
                  last, output ready);
endinterface

`default_nettype wire

### rtl/lpg_ctrl.sv
// Controller state machine for the permutation generator.
// Sequences load, restart and request handling; uses lpg_pkg command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module lpg_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    kind,
  input  wire lpg_pkg::lpg_sts_t sts,
  output lpg_pkg::lpg_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_SRCH  = 4'd3;
  localparam logic [3:0] S_SWAP  = 4'd4;
  localparam logic [3:0] S_REVA  = 4'd5;
  localparam logic [3:0] S_REVB  = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;
  localparam logic [3:0] S_MARK  = 4'd8;

  logic [3:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (kind)
            lpg_pkg::KIND_LOAD:    cmd.load    = 1'b1;
            lpg_pkg::KIND_RESTART: cmd.restart = 1'b1;
            lpg_pkg::KIND_REQUEST: begin
              cmd.start_req = 1'b1;
              if (!sts.lim_zero && sts.more) state_next = S_CHECK;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        if (!sts.first) begin
          cmd.set_first = 1'b1;
          state_next    = S_EMIT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan   = 1'b1;
        state_next = sts.found ? S_SRCH : S_MARK;
      end
      S_SRCH: begin
        cmd.srch   = 1'b1;
        state_next = S_SWAP;
      end
      S_SWAP: begin
        cmd.swap   = 1'b1;
        state_next = S_REVA;
      end
      S_REVA: begin
        if (sts.rev_go) begin
          cmd.rev_a  = 1'b1;
          state_next = S_REVB;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_REVB: begin
        cmd.rev_b  = 1'b1;
        state_next = S_REVA;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.j_last) state_next = sts.rem_one ? S_IDLE : S_CHECK;
        end
      end
      S_MARK: begin
        if (sts.out_free) begin
          cmd.mark   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### rtl/lpg_datapath.sv
// Datapath of the permutation generator: element table, index order, step pointers,
// count register and the result register. Uses lpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpg_datapath #(
  parameter int MAX_N       = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lpg_pkg::lpg_cmd_t cmd,
  output lpg_pkg::lpg_sts_t      sts,
  input  wire logic [2:0]        position,
  input  wire logic [31:0]       element_value,
  input  wire logic [3:0]        perm_count,
  input  wire logic              cfg_we,
  input  wire logic [3:0]        cfg_wdata,
  output logic [3:0]             count,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [31:0]            out_value,
  output logic [2:0]             out_index,
  output logic                   perm_end,
  output logic                   exhausted,
  output logic                   more_available,
  output logic                   last
);

  localparam int IW = $clog2(MAX_N);
  localparam int NW = $clog2(MAX_N + 1);

  logic [VALUE_WIDTH-1:0] store [MAX_N];
  logic [IW-1:0]          ord   [MAX_N];
  logic                   first, more;
  logic [IW-1:0]          a_ptr, k_ptr, lo, hi, j;
  logic [IW-1:0]          tmp;
  logic [3:0]             rem;

  logic [NW-1:0] n_eff;
  logic [IW-1:0] nm1, rd_addr, rd, scan_pos, k_sel;
  logic          found;
  logic [6:0]    maxp;
  logic [3:0]    lim;
  logic [7:0]    pos_w, slot_w;
  logic [63:0]   in_w, val_w;
  logic          restart_all;

  always_comb begin
    if (count == 4'd0) begin
      n_eff = NW'(1);
    end else if (int'(count) > MAX_N) begin
      n_eff = NW'(MAX_N);
    end else begin
      n_eff = NW'(count);
    end
  end

  assign nm1  = IW'(n_eff - NW'(1));
  assign maxp = lpg_pkg::max_perms(5'(n_eff));
  assign lim  = (7'(perm_count) < maxp) ? perm_count : maxp[3:0];

  // single read port into the index order
  always_comb begin
    if (cmd.srch) begin
      rd_addr = a_ptr - IW'(1);
    end else if (cmd.swap) begin
      rd_addr = k_ptr;
    end else if (cmd.rev_a) begin
      rd_addr = lo;
    end else if (cmd.rev_b) begin
      rd_addr = hi;
    end else begin
      rd_addr = j;
    end
  end
  assign rd = ord[rd_addr];

  // rightmost ascent
  always_comb begin
    found    = 1'b0;
    scan_pos = '0;
    for (int i = 1; i < MAX_N; i++) begin
      if (i < int'(n_eff) && ord[i] > ord[i-1]) begin
        found    = 1'b1;
        scan_pos = IW'(i);
      end
    end
  end

  // rightmost tail entry above the pivot
  always_comb begin
    k_sel = a_ptr;
    for (int i = 0; i < MAX_N; i++) begin
      if (IW'(i) >= a_ptr && i < int'(n_eff) && ord[i] > rd) k_sel = IW'(i);
    end
  end

  assign pos_w       = 8'(position);
  assign in_w        = 64'(element_value);
  assign slot_w      = 8'(rd);
  assign val_w       = 64'(store[rd]);
  assign restart_all = cfg_we || cmd.restart;

  always_ff @(posedge clk) begin
    if (cmd.load && int'(position) < MAX_N) store[pos_w[IW-1:0]] <= in_w[VALUE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || restart_all) begin
      for (int i = 0; i < MAX_N; i++) ord[i] <= IW'(i);
    end else if (cmd.swap) begin
      ord[a_ptr - IW'(1)] <= rd;
      ord[k_ptr]          <= tmp;
    end else if (cmd.rev_b) begin
      ord[lo] <= rd;
      ord[hi] <= tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= lpg_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart_all) begin
      first <= 1'b0;
      more  <= 1'b1;
    end else begin
      if (cmd.set_first) first <= 1'b1;
      if (cmd.mark) more <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j   <= '0;
      rem <= '0;
    end else if (cmd.start_req) begin
      j   <= '0;
      rem <= lim;
    end else if (cmd.emit) begin
      if (sts.j_last) begin
        j   <= '0;
        rem <= rem - 4'd1;
      end else begin
        j <= j + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      a_ptr <= scan_pos;
      lo    <= scan_pos;
      hi    <= nm1;
    end
    if (cmd.srch) begin
      k_ptr <= k_sel;
      tmp   <= rd;
    end
    if (cmd.rev_a) tmp <= rd;
    if (cmd.rev_b) begin
      lo <= lo + IW'(1);
      hi <= hi - IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.mark) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value      <= val_w[31:0];
      out_index      <= slot_w[2:0];
      perm_end       <= sts.j_last;
      exhausted      <= 1'b0;
      more_available <= 1'b1;
      last           <= sts.j_last && sts.rem_one;
    end else if (cmd.mark) begin
      out_value      <= '0;
      out_index      <= '0;
      perm_end       <= 1'b0;
      exhausted      <= 1'b1;
      more_available <= 1'b0;
      last           <= 1'b1;
    end
  end

  always_comb begin
    sts.first    = first;
    sts.more     = more;
    sts.lim_zero = (lim == 4'd0);
    sts.found    = found;
    sts.rev_go   = (lo < hi);
    sts.j_last   = (j == nm1);
    sts.rem_one  = (rem == 4'd1);
    sts.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

### rtl/lexicographic_permutation_generator_unit.sv
// Top level of the lexicographic permutation generator: channels, APB register port.
// Depends on lpg_pkg, lpg_if, lpg_ctrl and lpg_datapath.
//
// Load and restart requests are taken in the idle state. A request returns up to perm_count
// orderings of the first element_count table entries, one result per cycle within an
// ordering while the output is free. The first ordering after a restart is emitted as it
// stands; every later one is first stepped by scan, pivot search, swap and a tail reversal
// done one pair at a time, because all index moves go through one read port of the index
// order. The end-of-sequence marker follows a scan that finds no ascent. A new request is
// taken as soon as the last result of the previous one sits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module lexicographic_permutation_generator_unit #(
  parameter int MAX_N       = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  lpg_item_if.sink         items,
  lpg_result_if.source     results,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  lpg_pkg::lpg_cmd_t cmd;
  lpg_pkg::lpg_sts_t sts;
  logic              cfg_we;
  logic [3:0]        count;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == lpg_pkg::REG_ELEMENT_COUNT);
  assign prdata = (paddr[2] == lpg_pkg::REG_ELEMENT_COUNT) ? 32'(count) : 32'd0;

  lpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .kind     (items.kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpg_datapath #(
    .MAX_N       (MAX_N),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .position       (items.position),
    .element_value  (items.element_value),
    .perm_count     (items.perm_count),
    .cfg_we         (cfg_we),
    .cfg_wdata      (pwdata[3:0]),
    .count          (count),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .out_value      (results.out_value),
    .out_index      (results.out_index),
    .perm_end       (results.perm_end),
    .exhausted      (results.exhausted),
    .more_available (results.more_available),
    .last           (results.last)
  );

endmodule

`default_nettype wire

### rtl/lpg_checker.sv
// Port-level checks on the permutation generator result channel.
// Attached to lexicographic_permutation_generator_unit by the bind below.
`timescale 1ns / 1ps
`default_nettype none

module lpg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_value,
  input wire logic [2:0]  out_index,
  input wire logic        perm_end,
  input wire logic        exhausted,
  input wire logic        more_available,
  input wire logic        last
);

  a_marker_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && exhausted |-> last && !more_available && !perm_end &&
                               out_value == 32'd0 && out_index == 3'd0)
    else $error("marker carries data or is not last");

  a_element_more: assert property (@(posedge clk) disable iff (rst)
    out_valid && !exhausted |-> more_available)
    else $error("element result without more_available");

  a_last_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !exhausted && last |-> perm_end)
    else $error("request ended inside a permutation");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(last))
    else $error("stalled result changed");

endmodule

bind lexicographic_permutation_generator_unit lpg_checker u_lpg_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .out_value      (results.out_value),
  .out_index      (results.out_index),
  .perm_end       (results.perm_end),
  .exhausted      (results.exhausted),
  .more_available (results.more_available),
  .last           (results.last)
);

`default_nettype wire

### tb/tb_lexicographic_permutation_generator_unit.sv
// Self-checking bench for lexicographic_permutation_generator_unit: element loads, restarts,
// permutation requests and element_count writes, checked against an in-bench ordering model.
// Depends on lpg_pkg, lpg_if and the top level of the block.
`timescale 1ns / 1ps

module tb_lexicographic_permutation_generator_unit;

  localparam int          N_SLOTS   = 8;
  localparam int          RES_CAP   = 64;
  localparam int          SETTLE    = 64;
  localparam int          STALL_MAX = 2000;
  localparam int          SEG_ITEMS = 15;
  localparam logic [2:0]  CNT_ADDR  = 3'(4 * lpg_pkg::REG_ELEMENT_COUNT);

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  position;
    logic [31:0] element_value;
    logic [3:0]  perm_count;
  } lpg_req_t;

  typedef struct packed {
    logic [31:0] out_value;
    logic [2:0]  out_index;
    logic        perm_end;
    logic        exhausted;
    logic        more_available;
    logic        last;
  } lpg_res_t;

  typedef enum logic [1:0] {ROW_PRED, ROW_TYPED, ROW_CFG} row_op_t;

  typedef struct {
    row_op_t  op;
    lpg_req_t req;
    int       ntyped;
    lpg_res_t typed;
  } dir_row_t;

  localparam lpg_res_t MARKER_RES = '{out_value: 32'd0, out_index: 3'd0, perm_end: 1'b0,
                                      exhausted: 1'b1, more_available: 1'b0, last: 1'b1};
  localparam lpg_res_t NO_RES     = '0;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lpg_item_if   items_ch ();
  lpg_result_if results_ch ();

  lexicographic_permutation_generator_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ordering model state
  logic [31:0] elem_tbl [N_SLOTS];
  logic [2:0]  perm_idx [N_SLOTS];
  logic        first_done;
  logic        more_flag;
  logic [3:0]  count_reg;

  lpg_res_t    new_results [$];
  lpg_res_t    owed_results [$];
  dir_row_t    dir_rows [$];

  row_op_t     row_mode;
  int          typed_cnt;
  lpg_res_t    typed_val;

  int          src_gap_pct;
  int          sink_stall_pct;
  int          err_cnt;
  int          req_cnt;
  int          res_cnt;
  int          order_cnt;
  int          marker_cnt;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void reset_ordering();
    for (int i = 0; i < N_SLOTS; i++) perm_idx[i] = 3'(i);
    first_done = 1'b0;
    more_flag  = 1'b1;
  endfunction

  function automatic int active_n();
    int n;
    n = int'(count_reg);
    if (n < 1) n = 1;
    if (n > N_SLOTS) n = N_SLOTS;
    return n;
  endfunction

  function automatic void emit_ordering(input int n);
    lpg_res_t r;
    for (int j = 0; j < n; j++) begin
      r                = '0;
      r.out_value      = elem_tbl[perm_idx[j]];
      r.out_index      = perm_idx[j];
      r.perm_end       = (j == n - 1);
      r.more_available = 1'b1;
      new_results      = {new_results, r};
    end
  endfunction

  function automatic bit step_ordering(input int n);
    int         k;
    int         a;
    int         b;
    logic [2:0] t;
    for (int i = n - 1; i > 0; i--) begin
      if (perm_idx[i] > perm_idx[i-1]) begin
        k = n - 1;
        while (k > i && perm_idx[i-1] > perm_idx[k]) k--;
        t = perm_idx[i-1];
        perm_idx[i-1] = perm_idx[k];
        perm_idx[k] = t;
        a = i;
        b = n - 1;
        while (a < b) begin
          t = perm_idx[a];
          perm_idx[a] = perm_idx[b];
          perm_idx[b] = t;
          a++;
          b--;
        end
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void apply_item(input lpg_req_t r);
    int n;
    int lim;
    int tail;
    new_results.delete();
    case (r.kind)
      lpg_pkg::KIND_LOAD:    elem_tbl[r.position] = r.element_value;
      lpg_pkg::KIND_RESTART: reset_ordering();
      lpg_pkg::KIND_REQUEST: begin
        n   = active_n();
        lim = int'(r.perm_count);
        if (lim > RES_CAP / n) lim = RES_CAP / n;
        for (int c = 0; c < lim && more_flag; c++) begin
          if (!first_done) begin
            emit_ordering(n);
            first_done = 1'b1;
          end else if (step_ordering(n)) begin
            emit_ordering(n);
          end else begin
            more_flag   = 1'b0;
            new_results = {new_results, MARKER_RES};
          end
        end
        tail = new_results.size() - 1;
        if (tail >= 0) new_results[tail].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("[%0t] %s mismatch: expected %0h, got %0h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  // scoreboard: results, accepted requests and register accesses, all at the rising edge
  always @(posedge clk) begin
    lpg_res_t want;
    lpg_req_t req;
    if (!rst && results_ch.valid && results_ch.ready) begin
      res_cnt++;
      if (results_ch.perm_end) order_cnt++;
      if (results_ch.exhausted) marker_cnt++;
      if (owed_results.size() == 0) begin
        $display("[%0t] unexpected result: value %0h index %0d", $time,
                 results_ch.out_value, results_ch.out_index);
        err_cnt++;
      end else begin
        want = owed_results.pop_front();
        check_field("out_value", want.out_value, results_ch.out_value);
        check_field("out_index", 32'(want.out_index), 32'(results_ch.out_index));
        check_field("perm_end", 32'(want.perm_end), 32'(results_ch.perm_end));
        check_field("exhausted", 32'(want.exhausted), 32'(results_ch.exhausted));
        check_field("more_available", 32'(want.more_available),
                    32'(results_ch.more_available));
        check_field("last", 32'(want.last), 32'(results_ch.last));
      end
    end
    if (!rst && items_ch.valid && items_ch.ready) begin
      req = '{kind: items_ch.kind, position: items_ch.position,
              element_value: items_ch.element_value, perm_count: items_ch.perm_count};
      if (req.kind == lpg_pkg::KIND_REQUEST) req_cnt++;
      apply_item(req);
      if (row_mode == ROW_TYPED) begin
        new_results.delete();
        if (typed_cnt > 0) new_results = {new_results, typed_val};
      end
      owed_results = {owed_results, new_results};
    end
    if (!rst && psel && penable && pready) begin
      if (pwrite) begin
        count_reg = pwdata[3:0];
        reset_ordering();
      end else begin
        check_field("element_count readback", {28'd0, count_reg}, prdata);
      end
    end
  end

  initial begin : watchdog
    int stall_run;
    stall_run = 0;
    while (stall_run < STALL_MAX) begin
      @(posedge clk);
      if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready) || psel)
        stall_run = 0;
      else
        stall_run++;
    end
    $display("[%0t] no progress for %0d cycles, %0d results still owed", $time, STALL_MAX,
             owed_results.size());
    $display("== FAIL ==");
    $finish;
  end

  always @(negedge clk) begin
    results_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_item(input lpg_req_t r, input row_op_t mode, input int ntyped,
                           input lpg_res_t tres);
    while ($urandom_range(99) < src_gap_pct) begin
      items_ch.valid <= 1'b0;
      @(negedge clk);
    end
    row_mode  = mode;
    typed_cnt = ntyped;
    typed_val = tres;
    items_ch.valid         <= 1'b1;
    items_ch.kind          <= r.kind;
    items_ch.position      <= r.position;
    items_ch.element_value <= r.element_value;
    items_ch.perm_count    <= r.perm_count;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    items_ch.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CNT_ADDR;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
  endtask

  // drains the request channel and lets the block settle before the write and readback
  task automatic set_element_count(input logic [3:0] v);
    wait_all_results();
    repeat (SETTLE) @(negedge clk);
    apb_xfer(1'b1, {28'd0, v});
    apb_xfer(1'b0, 32'd0);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  function automatic void add_row(input row_op_t op, input logic [1:0] kind,
                                  input logic [2:0] pos, input logic [31:0] val,
                                  input logic [3:0] cnt, input int ntyped,
                                  input lpg_res_t tres);
    dir_row_t d;
    d.op     = op;
    d.req    = '{kind: kind, position: pos, element_value: val, perm_count: cnt};
    d.ntyped = ntyped;
    d.typed  = tres;
    dir_rows = {dir_rows, d};
  endfunction

  function automatic lpg_req_t rand_item();
    lpg_req_t r;
    int       roll;
    r.kind          = 2'($urandom_range(3));
    r.position      = 3'($urandom_range(7));
    r.element_value = $urandom;
    r.perm_count    = 4'($urandom_range(1, 15));
    roll            = $urandom_range(99);
    if (roll < 8) begin
      r.kind = 2'd3;
    end else if (roll < 22) begin
      r.kind = lpg_pkg::KIND_LOAD;
      case ($urandom_range(7))
        0: r.element_value = 32'd0;
        1: r.element_value = 32'hFFFF_FFFF;
        default: ;
      endcase
    end else if (roll < 33) begin
      r.kind = lpg_pkg::KIND_RESTART;
    end else if (roll < 37) begin
      r.kind       = lpg_pkg::KIND_REQUEST;
      r.perm_count = 4'd0;
    end else begin
      r.kind = lpg_pkg::KIND_REQUEST;
    end
    return r;
  endfunction

  initial begin
    logic [3:0] seg_counts [3][5];
    int         src_pcts [3];
    int         sink_pcts [3];

    seg_counts = '{'{4'd3, 4'd1, 4'd8, 4'd0, 4'd4},
                   '{4'd2, 4'd5, 4'd15, 4'd6, 4'd3},
                   '{4'd7, 4'd4, 4'd9, 4'd1, 4'd12}};
    src_pcts   = '{13, 51, 0};
    sink_pcts  = '{51, 13, 0};

    rst                    = 1'b1;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    items_ch.valid         = 1'b0;
    items_ch.kind          = lpg_pkg::KIND_LOAD;
    items_ch.position      = '0;
    items_ch.element_value = '0;
    items_ch.perm_count    = '0;
    results_ch.ready       = 1'b0;
    src_gap_pct            = src_pcts[0];
    sink_stall_pct         = sink_pcts[0];
    row_mode               = ROW_PRED;
    typed_cnt              = 0;
    typed_val              = NO_RES;
    err_cnt                = 0;
    req_cnt                = 0;
    res_cnt                = 0;
    order_cnt              = 0;
    marker_cnt             = 0;
    count_reg              = lpg_pkg::COUNT_RESET;
    foreach (elem_tbl[i]) elem_tbl[i] = '0;
    reset_ordering();

    // fill every slot first: the table is never read before it is written
    add_row(ROW_PRED, lpg_pkg::KIND_LOAD, 3'd0, 32'h0000_0000, 4'd0, 0, NO_RES);
    add_row(ROW_PRED, lpg_pkg::KIND_LOAD, 3'd7, 32'hFFFF_FFFF, 4'd0, 0, NO_RES);
    add_row(ROW_PRED, lpg_pkg::KIND_LOAD, 3'd1, 32'h1234_5678, 4'd0, 0, NO_RES);
    add_row(ROW_PRED, lpg_pkg::KIND_LOAD, 3'd2, 32'h8000_0001, 4'd0, 0, NO_RES);
    add_row(ROW_PRED, lpg_pkg::KIND_LOAD, 3'd3, 32'h7FFF_FFFE, 4'd0, 0, NO_RES);
    add_row(ROW_PRED, lpg_pkg::KIND_LOAD, 3'd4, 32'hA5A5_A5A5, 4'd0, 0, NO_RES);
    add_row(ROW_PRED, lpg_pkg::KIND_LOAD, 3'd5, 32'h5A5A_5A5A, 4'd0, 0, NO_RES);
    add_row(ROW_PRED, lpg_pkg::KIND_LOAD, 3'd6, 32'h0F0F_F0F0, 4'd0, 0, NO_RES);
    // unused kind and zero count: nothing comes back
    add_row(ROW_TYPED, 2'd3, 3'd7, 32'hFFFF_FFFF, 4'd15, 0, NO_RES);
    add_row(ROW_TYPED, lpg_pkg::KIND_REQUEST, 3'd0, 32'd0, 4'd0, 0, NO_RES);
    add_row(ROW_PRED, lpg_pkg::KIND_REQUEST, 3'd0, 32'd0, 4'd1, 0, NO_RES);
    add_row(ROW_PRED, lpg_pkg::KIND_REQUEST, 3'd0, 32'd0, 4'd15, 0, NO_RES);
    add_row(ROW_CFG, lpg_pkg::KIND_LOAD, 3'd0, 32'd0, 4'd1, 0, NO_RES);
    add_row(ROW_PRED, lpg_pkg::KIND_REQUEST, 3'd0, 32'd0, 4'd3, 0, NO_RES);
    add_row(ROW_TYPED, lpg_pkg::KIND_REQUEST, 3'd0, 32'd0, 4'd1, 0, NO_RES);
    add_row(ROW_TYPED, lpg_pkg::KIND_RESTART, 3'd0, 32'd0, 4'd0, 0, NO_RES);
    add_row(ROW_PRED, lpg_pkg::KIND_REQUEST, 3'd0, 32'd0, 4'd15, 0, NO_RES);
    add_row(ROW_CFG, lpg_pkg::KIND_LOAD, 3'd0, 32'd0, 4'd0, 0, NO_RES);
    add_row(ROW_PRED, lpg_pkg::KIND_REQUEST, 3'd0, 32'd0, 4'd2, 0, NO_RES);
    add_row(ROW_CFG, lpg_pkg::KIND_LOAD, 3'd0, 32'd0, 4'd15, 0, NO_RES);
    add_row(ROW_PRED, lpg_pkg::KIND_REQUEST, 3'd0, 32'd0, 4'd15, 0, NO_RES);
    add_row(ROW_CFG, lpg_pkg::KIND_LOAD, 3'd0, 32'd0, 4'd2, 0, NO_RES);
    add_row(ROW_PRED, lpg_pkg::KIND_REQUEST, 3'd0, 32'd0, 4'd2, 0, NO_RES);
    add_row(ROW_TYPED, lpg_pkg::KIND_REQUEST, 3'd0, 32'd0, 4'd4, 1, MARKER_RES);
    add_row(ROW_TYPED, lpg_pkg::KIND_RESTART, 3'd0, 32'd0, 4'd0, 0, NO_RES);
    add_row(ROW_PRED, lpg_pkg::KIND_LOAD, 3'd0, 32'hFFFF_FFFF, 4'd0, 0, NO_RES);
    add_row(ROW_CFG, lpg_pkg::KIND_LOAD, 3'd0, 32'd0, 4'd5, 0, NO_RES);
    add_row(ROW_PRED, lpg_pkg::KIND_REQUEST, 3'd0, 32'd0, 4'd15, 0, NO_RES);
    add_row(ROW_PRED, lpg_pkg::KIND_REQUEST, 3'd0, 32'd0, 4'd3, 0, NO_RES);
    add_row(ROW_CFG, lpg_pkg::KIND_LOAD, 3'd0, 32'd0, 4'd8, 0, NO_RES);
    add_row(ROW_PRED, lpg_pkg::KIND_RESTART, 3'd0, 32'd0, 4'd0, 0, NO_RES);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset value of element_count
    apb_xfer(1'b0, 32'd0);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_CFG)
        set_element_count(dir_rows[i].req.perm_count);
      else
        send_item(dir_rows[i].req, dir_rows[i].op, dir_rows[i].ntyped, dir_rows[i].typed);
    end

    for (int m = 0; m < 3; m++) begin
      src_gap_pct    = src_pcts[m];
      sink_stall_pct = sink_pcts[m];
      for (int s = 0; s < 5; s++) begin
        set_element_count(seg_counts[m][s]);
        for (int k = 0; k < SEG_ITEMS; k++) begin
          if (k == SEG_ITEMS / 2) wait_all_results();
          send_item(rand_item(), ROW_PRED, 0, NO_RES);
        end
      end
    end

    wait_all_results();
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d requests over element counts 0..15 under three idling mixes;",
             req_cnt);
    $display("checked %0d results: %0d orderings, %0d exhaustion markers, %0d errors.",
             res_cnt, order_cnt, marker_cnt, err_cnt);
    if (err_cnt == 0 && owed_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
